>>> rtl/instruction_operand_decoder_defines.svh
// ----------------------------------------------------------------------------
// instruction_operand_decoder_defines
// Assertion macros for the operand decoder, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef INSTRUCTION_OPERAND_DECODER_DEFINES_SVH
`define INSTRUCTION_OPERAND_DECODER_DEFINES_SVH

// same-cycle property
`define IOD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in this cycle, consequent in the next
`define IOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/iod_pkg.sv
// ----------------------------------------------------------------------------
// iod_pkg
// Shared widths, codes and helpers of the instruction operand decoder.
// ----------------------------------------------------------------------------
package iod_pkg;

  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned ALLOW_W = 3;
  localparam int unsigned DSZ_W   = 3;
  localparam int unsigned NARGS   = 3;

  localparam int unsigned ARENA_SIZE_DEF     = 4096;
  localparam int unsigned MAX_ARGS_DEF       = 3;
  localparam int unsigned REGISTER_COUNT_DEF = 16;

  localparam logic [DSZ_W-1:0] DIRECT_SHORT = 3'd2;

  // bit positions in an allowed-kinds mask
  localparam int unsigned ALLOW_REG = 0;
  localparam int unsigned ALLOW_DIR = 1;
  localparam int unsigned ALLOW_IND = 2;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_DECODE = 1'b1
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_REG  = 2'd1,
    KIND_DIR  = 2'd2,
    KIND_IND  = 2'd3
  } kind_e;

  // bytes an argument occupies in the arena
  function automatic logic [2:0] kind_len(input kind_e k, input logic dir2);
    logic [2:0] len;
    unique case (k)
      KIND_REG: len = 3'd1;
      KIND_DIR: len = dir2 ? 3'd2 : 3'd4;
      KIND_IND: len = 3'd2;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/iod_if.sv
// ----------------------------------------------------------------------------
// iod_if
// Request and result channels of the operand decoder, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iod_req_if
  import iod_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               action;
  logic [ADDR_W-1:0]  address;
  logic [DATA_W-1:0]  data;
  logic               has_type_byte;
  logic [CNT_W-1:0]   arg_count;
  logic [ALLOW_W-1:0] allowed_kinds_0;
  logic [ALLOW_W-1:0] allowed_kinds_1;
  logic [ALLOW_W-1:0] allowed_kinds_2;
  logic [DSZ_W-1:0]   direct_size;

  modport source (
    output valid, action, address, data, has_type_byte, arg_count,
           allowed_kinds_0, allowed_kinds_1, allowed_kinds_2, direct_size,
    input  ready
  );
  modport sink (
    input  valid, action, address, data, has_type_byte, arg_count,
           allowed_kinds_0, allowed_kinds_1, allowed_kinds_2, direct_size,
    output ready
  );
endinterface

interface iod_rsp_if
  import iod_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       arg_kind_0;
  logic [KIND_W-1:0]       arg_kind_1;
  logic [KIND_W-1:0]       arg_kind_2;
  logic signed [VAL_W-1:0] arg_value_0;
  logic signed [VAL_W-1:0] arg_value_1;
  logic signed [VAL_W-1:0] arg_value_2;
  logic                    args_ok;
  logic [ADDR_W-1:0]       next_address;

  modport source (
    output valid, arg_kind_0, arg_kind_1, arg_kind_2, arg_value_0, arg_value_1,
           arg_value_2, args_ok, next_address,
    input  ready
  );
  modport sink (
    input  valid, arg_kind_0, arg_kind_1, arg_kind_2, arg_value_0, arg_value_1,
           arg_value_2, args_ok, next_address,
    output ready
  );
endinterface

>>> rtl/iod_arena.sv
// ----------------------------------------------------------------------------
// iod_arena
// Single-port byte memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module iod_arena
  import iod_pkg::*;
#(
  parameter int unsigned DEPTH = ARENA_SIZE_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/instruction_operand_decoder.sv
// ----------------------------------------------------------------------------
// instruction_operand_decoder: a write folds its address, stores the byte and returns to
// idle. Decode of N operand bytes (N <= 12, one per cycle on the single port) reads the
// type byte first if present; the next request is taken as the result appears. The address
// is folded by repeated subtraction of ARENA_SIZE, and a result not yet taken holds back the
// next decode's result. Reset: control only; arena bytes are undefined until written.
// ----------------------------------------------------------------------------
module instruction_operand_decoder
  import iod_pkg::*;
#(
  parameter int unsigned ARENA_SIZE     = ARENA_SIZE_DEF,
  parameter int unsigned MAX_ARGS       = MAX_ARGS_DEF,
  parameter int unsigned REGISTER_COUNT = REGISTER_COUNT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  iod_req_if.sink  req_i,
  iod_rsp_if.source rsp_o
);

  `include "instruction_operand_decoder_defines.svh"

  localparam int unsigned AW = $clog2(ARENA_SIZE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_TB,
    S_TBW,
    S_STREAM,
    S_DONE
  } state_e;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (32'(a) == ARENA_SIZE - 1) ? '0 : a + 1'b1;
  endfunction

  // control
  state_e      state_q, state_d;
  logic [3:0]  iss_left_q, iss_left_d;
  logic        rd_pend_q, rd_pend_d;
  logic [3:0]  b_q, b_d;
  logic        out_valid_q, out_valid_d;
  logic [4:0]  stream_sum;

  // request payload and working registers
  action_e           act_q, act_d;
  logic [ADDR_W-1:0] red_q, red_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic              has_tb_q, has_tb_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ALLOW_W-1:0] allow_q [NARGS];
  logic [ALLOW_W-1:0] allow_d [NARGS];
  logic              dir2_q, dir2_d;
  logic [AW-1:0]     pos_q, pos_d;
  kind_e             kinds_q [NARGS];
  kind_e             kinds_d [NARGS];
  logic [VAL_W-1:0]  vals_q [NARGS];
  logic [VAL_W-1:0]  vals_d [NARGS];
  logic [2:0]        end0_q, end0_d;
  logic [3:0]        end1_q, end1_d;
  logic [3:0]        total_q, total_d;

  // result register
  logic [KIND_W-1:0] okind_q [NARGS];
  logic [KIND_W-1:0] okind_d [NARGS];
  logic [VAL_W-1:0]  oval_q [NARGS];
  logic [VAL_W-1:0]  oval_d [NARGS];
  logic              ook_q, ook_d;
  logic [ADDR_W-1:0] onext_q, onext_d;

  // memory port
  logic              mem_en, mem_we;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_rdata;

  // stream setup
  kind_e             k_new [NARGS];
  logic [2:0]        len_new [NARGS];
  logic [CNT_W-1:0]  cnt_new;
  logic [CNT_W-1:0]  cnt_sat;
  logic [1:0]        sel;
  logic              short_val;
  logic              ok;

  iod_arena #(
    .DEPTH (ARENA_SIZE),
    .AW    (AW)
  ) u_arena (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (data_q),
    .rdata_o (mem_rdata)
  );

  assign cnt_sat = (32'(req_i.arg_count) > MAX_ARGS) ? CNT_W'(MAX_ARGS) : req_i.arg_count;

  // argument kinds and byte lengths, from the type byte or implied direct
  always_comb begin
    for (int i = 0; i < NARGS; i++) begin
      if (has_tb_q) begin
        k_new[i] = (32'(cnt_q) > i) ? kind_e'(mem_rdata[7 - 2*i -: 2]) : KIND_NONE;
      end else begin
        k_new[i] = (i == 0 && cnt_q != '0) ? KIND_DIR : KIND_NONE;
      end
      len_new[i] = kind_len(k_new[i], dir2_q);
    end
    cnt_new = has_tb_q ? cnt_q : ((cnt_q != '0) ? CNT_W'(1) : '0);
  end

  assign sel = (b_q < 4'(end0_q)) ? 2'd0 : ((b_q < end1_q) ? 2'd1 : 2'd2);

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    iss_left_d  = iss_left_q;
    rd_pend_d   = rd_pend_q;
    b_d         = b_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    act_d       = act_q;
    red_d       = red_q;
    data_d      = data_q;
    has_tb_d    = has_tb_q;
    cnt_d       = cnt_q;
    allow_d     = allow_q;
    dir2_d      = dir2_q;
    pos_d       = pos_q;
    kinds_d     = kinds_q;
    vals_d      = vals_q;
    end0_d      = end0_q;
    end1_d      = end1_q;
    total_d     = total_q;
    okind_d     = okind_q;
    oval_d      = oval_q;
    ook_d       = ook_q;
    onext_d     = onext_q;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = pos_q;
    short_val   = 1'b0;
    ok          = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d      = action_e'(req_i.action);
          red_d      = req_i.address;
          data_d     = req_i.data;
          has_tb_d   = req_i.has_type_byte;
          cnt_d      = cnt_sat;
          allow_d[0] = req_i.allowed_kinds_0;
          allow_d[1] = req_i.allowed_kinds_1;
          allow_d[2] = req_i.allowed_kinds_2;
          dir2_d     = (req_i.direct_size == DIRECT_SHORT);
          for (int i = 0; i < NARGS; i++) begin
            kinds_d[i] = KIND_NONE;
            vals_d[i]  = '0;
          end
          state_d = S_WRAP;
        end
      end

      S_WRAP: begin
        // fold the address into the arena, one subtraction per cycle
        if (32'(red_q) >= ARENA_SIZE) begin
          red_d = red_q - ADDR_W'(ARENA_SIZE);
        end else if (act_q == ACT_WRITE) begin
          mem_en   = 1'b1;
          mem_we   = 1'b1;
          mem_addr = AW'(red_q);
          state_d  = S_IDLE;
        end else begin
          pos_d = wrap_inc(AW'(red_q));
          if (has_tb_q) begin
            state_d = S_TB;
          end else begin
            kinds_d    = k_new;
            cnt_d      = cnt_new;
            end0_d     = len_new[0];
            end1_d     = 4'(len_new[0]) + 4'(len_new[1]);
            total_d    = 4'(len_new[0]) + 4'(len_new[1]) + 4'(len_new[2]);
            iss_left_d = 4'(len_new[0]) + 4'(len_new[1]) + 4'(len_new[2]);
            b_d        = '0;
            rd_pend_d  = 1'b0;
            state_d    = S_STREAM;
          end
        end
      end

      S_TB: begin
        mem_en  = 1'b1;
        pos_d   = wrap_inc(pos_q);
        state_d = S_TBW;
      end

      S_TBW: begin
        kinds_d    = k_new;
        cnt_d      = cnt_new;
        end0_d     = len_new[0];
        end1_d     = 4'(len_new[0]) + 4'(len_new[1]);
        total_d    = 4'(len_new[0]) + 4'(len_new[1]) + 4'(len_new[2]);
        iss_left_d = 4'(len_new[0]) + 4'(len_new[1]) + 4'(len_new[2]);
        b_d        = '0;
        rd_pend_d  = 1'b0;
        state_d    = S_STREAM;
      end

      S_STREAM: begin
        // issue one read per cycle; the byte from last cycle lands in its argument
        if (iss_left_q != '0) begin
          mem_en     = 1'b1;
          pos_d      = wrap_inc(pos_q);
          iss_left_d = iss_left_q - 4'd1;
        end
        rd_pend_d = (iss_left_q != '0);
        if (rd_pend_q) begin
          for (int i = 0; i < NARGS; i++) begin
            if (32'(sel) == i) begin
              vals_d[i] = {vals_q[i][VAL_W-DATA_W-1:0], mem_rdata};
            end
          end
          b_d = b_q + 4'd1;
        end
        if (iss_left_q == '0 && !rd_pend_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          for (int i = 0; i < NARGS; i++) begin
            short_val  = (kinds_q[i] == KIND_IND) || (kinds_q[i] == KIND_DIR && dir2_q);
            okind_d[i] = kinds_q[i];
            oval_d[i]  = short_val ? {{(VAL_W-16){vals_q[i][15]}}, vals_q[i][15:0]}
                                   : vals_q[i];
            if (32'(cnt_q) > i) begin
              case (kinds_q[i])
                KIND_REG: begin
                  if (!allow_q[i][ALLOW_REG] || vals_q[i] == '0 ||
                      vals_q[i] > VAL_W'(REGISTER_COUNT)) begin
                    ok = 1'b0;
                  end
                end
                KIND_DIR: if (!allow_q[i][ALLOW_DIR]) ok = 1'b0;
                KIND_IND: if (!allow_q[i][ALLOW_IND]) ok = 1'b0;
                default:  ok = 1'b0;
              endcase
            end
          end
          ook_d       = ok;
          onext_d     = ADDR_W'(pos_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iss_left_q  <= '0;
      rd_pend_q   <= 1'b0;
      b_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_left_q  <= iss_left_d;
      rd_pend_q   <= rd_pend_d;
      b_q         <= b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    red_q    <= red_d;
    data_q   <= data_d;
    has_tb_q <= has_tb_d;
    cnt_q    <= cnt_d;
    allow_q  <= allow_d;
    dir2_q   <= dir2_d;
    pos_q    <= pos_d;
    kinds_q  <= kinds_d;
    vals_q   <= vals_d;
    end0_q   <= end0_d;
    end1_q   <= end1_d;
    total_q  <= total_d;
    okind_q  <= okind_d;
    oval_q   <= oval_d;
    ook_q    <= ook_d;
    onext_q  <= onext_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.arg_kind_0   = okind_q[0];
  assign rsp_o.arg_kind_1   = okind_q[1];
  assign rsp_o.arg_kind_2   = okind_q[2];
  assign rsp_o.arg_value_0  = oval_q[0];
  assign rsp_o.arg_value_1  = oval_q[1];
  assign rsp_o.arg_value_2  = oval_q[2];
  assign rsp_o.args_ok      = ook_q;
  assign rsp_o.next_address = onext_q;

  // during the stream, landed, in-flight and still-to-issue bytes add up to the operand byte total
  assign stream_sum = 5'(b_q) + 5'(iss_left_q) + 5'(rd_pend_q);

  `IOD_ASSERT(a_stream_count, state_q != S_STREAM || stream_sum == 5'(total_q), "stream count")
  `IOD_ASSERT(a_done_drained, state_q != S_DONE || (!rd_pend_q && iss_left_q == '0), "reads left")
  `IOD_ASSERT_NEXT(a_tb_read, state_q == S_TB, state_q == S_TBW && !rd_pend_q, "no type capture")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for instruction_operand_decoder. A behavioral copy of
// the byte arena predicts decodes the directed table gives no result for. The
// table runs first, then random write/decode traffic, random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench
  import iod_pkg::*;
();

  localparam int unsigned ARENA_BYTES = ARENA_SIZE_DEF;
  localparam int unsigned REG_LAST    = REGISTER_COUNT_DEF;
  localparam int unsigned ITEM_GOAL   = 1700;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned DRAIN_EVERY = 500;
  localparam int unsigned PRINT_CAP   = 100;

  typedef struct packed {
    action_e                       action;
    logic [ADDR_W-1:0]             address;
    logic [DATA_W-1:0]             data;
    logic                          has_type_byte;
    logic [CNT_W-1:0]              arg_count;
    logic [NARGS-1:0][ALLOW_W-1:0] allowed;
    logic [DSZ_W-1:0]              direct_size;
  } request_t;

  typedef struct packed {
    logic [NARGS-1:0][KIND_W-1:0] kind;
    logic [NARGS-1:0][VAL_W-1:0]  value;
    logic                         ok;
    logic [ADDR_W-1:0]            next;
  } decode_result_t;

  typedef struct {
    request_t       req;
    bit             typed;
    decode_result_t want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  iod_req_if req_if ();
  iod_rsp_if rsp_if ();

  instruction_operand_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [DATA_W-1:0] arena_copy [ARENA_BYTES];
  bit                arena_set  [ARENA_BYTES];
  decode_result_t    decodes_due [$];
  logic [ADDR_W-1:0] opcode_sites [$];
  plan_row_t         directed_plan [24];
  int unsigned       mismatches;
  int unsigned       items_sent;
  bit                sender_calm;
  bit                receiver_calm;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // ---- operand walk over the arena copy ----

  // also notes the first byte of the footprint that was never written
  function automatic logic [DATA_W-1:0] fetch_byte(input logic [ADDR_W-1:0] at,
                                                   inout int first_gap);
    if (!arena_set[at] && first_gap < 0) first_gap = int'(at);
    return arena_copy[at];
  endfunction

  function automatic logic [VAL_W-1:0] read_value(inout logic [ADDR_W-1:0] pos,
                                                  input int len, inout int first_gap);
    logic [VAL_W-1:0] v;
    v = '0;
    for (int b = 0; b < len; b++) begin
      v = {v[VAL_W-9:0], fetch_byte(pos, first_gap)};
      pos = pos + 1'b1;
    end
    if (len == 2) v = {{16{v[15]}}, v[15:0]};
    return v;
  endfunction

  function automatic void walk_operands(input request_t r, output decode_result_t res,
                                        output int first_gap);
    logic [ADDR_W-1:0] pos;
    logic [DATA_W-1:0] tb;
    logic [CNT_W-1:0]  n;
    logic [VAL_W-1:0]  v;
    kind_e             k;
    int                dir_len;
    res       = '0;
    res.ok    = 1'b1;
    first_gap = -1;
    dir_len   = (r.direct_size == DIRECT_SHORT) ? 2 : 4;
    void'(fetch_byte(r.address, first_gap));
    pos = r.address + 1'b1;
    n   = r.arg_count;
    if (r.has_type_byte) begin
      tb = DATA_W'(read_value(pos, 1, first_gap));
      for (int i = 0; i < n; i++) res.kind[i] = tb[7-2*i -: 2];
    end else if (n != 0) begin
      // without a type byte there is a single direct operand
      n = 1;
      res.kind[0] = KIND_DIR;
    end
    for (int i = 0; i < n; i++) begin
      k = kind_e'(res.kind[i]);
      case (k)
        KIND_REG: begin
          v = read_value(pos, 1, first_gap);
          if (!r.allowed[i][ALLOW_REG] || v < 1 || v > REG_LAST) res.ok = 1'b0;
        end
        KIND_DIR: begin
          v = read_value(pos, dir_len, first_gap);
          if (!r.allowed[i][ALLOW_DIR]) res.ok = 1'b0;
        end
        KIND_IND: begin
          v = read_value(pos, 2, first_gap);
          if (!r.allowed[i][ALLOW_IND]) res.ok = 1'b0;
        end
        default: begin
          v = '0;
          res.ok = 1'b0;
        end
      endcase
      res.value[i] = v;
    end
    res.next = pos;
  endfunction

  function automatic void apply_request(input request_t r, input bit typed,
                                        input decode_result_t want);
    decode_result_t res;
    int             gap_at;
    if (r.action == ACT_WRITE) begin
      arena_copy[r.address] = r.data;
      arena_set[r.address]  = 1'b1;
    end else begin
      walk_operands(r, res, gap_at);
      decodes_due.push_back(typed ? want : res);
    end
  endfunction

  // ---- request builders ----

  function automatic request_t arena_write(input logic [ADDR_W-1:0] at,
                                           input logic [DATA_W-1:0] value);
    request_t r;
    r         = '0;
    r.action  = ACT_WRITE;
    r.address = at;
    r.data    = value;
    return r;
  endfunction

  function automatic request_t decode_req(input logic [ADDR_W-1:0] at, input logic tb,
                                          input logic [CNT_W-1:0] cnt,
                                          input logic [ALLOW_W-1:0] a0, a1, a2,
                                          input logic [DSZ_W-1:0] dsz);
    request_t r;
    r               = '0;
    r.action        = ACT_DECODE;
    r.address       = at;
    r.has_type_byte = tb;
    r.arg_count     = cnt;
    r.allowed       = {a2, a1, a0};
    r.direct_size   = dsz;
    return r;
  endfunction

  function automatic decode_result_t outcome(input kind_e k0, k1, k2,
                                             input logic [VAL_W-1:0] v0, v1, v2,
                                             input logic ok, input logic [ADDR_W-1:0] nxt);
    decode_result_t res;
    res.kind  = {k2, k1, k0};
    res.value = {v2, v1, v0};
    res.ok    = ok;
    res.next  = nxt;
    return res;
  endfunction

  // ---- random values ----

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [DATA_W-1:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return DATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] register_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return DATA_W'(REG_LAST + 1);
      2:       return 8'hFF;
      default: return DATA_W'($urandom_range(1, REG_LAST));
    endcase
  endfunction

  // ---- request channel ----

  task automatic send_request(input request_t r, input bit typed = 1'b0,
                              input decode_result_t want = '0);
    int unsigned gap;
    gap = sender_calm ? 0 : pause_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.action          <= r.action;
    req_if.address         <= r.address;
    req_if.data            <= r.data;
    req_if.has_type_byte   <= r.has_type_byte;
    req_if.arg_count       <= r.arg_count;
    req_if.allowed_kinds_0 <= r.allowed[0];
    req_if.allowed_kinds_1 <= r.allowed[1];
    req_if.allowed_kinds_2 <= r.allowed[2];
    req_if.direct_size     <= r.direct_size;
    req_if.valid           <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    apply_request(r, typed, want);
    items_sent++;
  endtask

  task automatic write_byte(input logic [ADDR_W-1:0] at, input logic [DATA_W-1:0] value);
    send_request(arena_write(at, value));
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (decodes_due.size() != 0);
  endtask

  // fill any never-written byte in the footprint before decoding
  task automatic decode_filled(input request_t d);
    decode_result_t probe;
    int             gap_at;
    walk_operands(d, probe, gap_at);
    while (gap_at >= 0) begin
      write_byte(ADDR_W'(gap_at), random_byte());
      walk_operands(d, probe, gap_at);
    end
    send_request(d);
  endtask

  // well-formed instruction: opcode, optional type byte, operands matching the codes
  task automatic fresh_instruction();
    logic [ADDR_W-1:0] at;
    logic [ADDR_W-1:0] pos;
    logic [DATA_W-1:0] tb;
    kind_e             k [NARGS];
    request_t          d;
    int unsigned       n;
    int unsigned       sel;
    sel = $urandom_range(0, 9);
    if (sel < 7)      at = ADDR_W'($urandom_range(0, 255));
    else if (sel < 9) at = ADDR_W'($urandom_range(ARENA_BYTES - 16, ARENA_BYTES - 1));
    else              at = ADDR_W'($urandom_range(0, ARENA_BYTES - 1));
    d               = '0;
    d.action        = ACT_DECODE;
    d.address       = at;
    d.has_type_byte = ($urandom_range(0, 3) != 0);
    d.arg_count     = ($urandom_range(0, 11) == 0) ? CNT_W'(0) : CNT_W'($urandom_range(1, 3));
    if ($urandom_range(0, 3) == 0) d.direct_size = DSZ_W'($urandom_range(0, 7));
    else d.direct_size = $urandom_range(0, 1) ? DIRECT_SHORT : DSZ_W'(4);
    for (int i = 0; i < NARGS; i++)
      k[i] = ($urandom_range(0, 9) == 0) ? KIND_NONE : kind_e'($urandom_range(1, 3));
    tb = {k[0], k[1], k[2], 2'($urandom_range(0, 3))};
    n  = d.arg_count;
    if (!d.has_type_byte) begin
      k[0] = KIND_DIR;
      if (n > 1) n = 1;
    end
    for (int i = 0; i < NARGS; i++) begin
      d.allowed[i] = ALLOW_W'($urandom_range(0, 7));
      if (k[i] != KIND_NONE && $urandom_range(0, 4) != 0) d.allowed[i][int'(k[i]) - 1] = 1'b1;
    end
    write_byte(at, random_byte());
    pos = at + 1'b1;
    if (d.has_type_byte) begin
      write_byte(pos, tb);
      pos++;
    end
    for (int i = 0; i < n; i++) begin
      case (k[i])
        KIND_REG: begin
          write_byte(pos, register_byte());
          pos++;
        end
        KIND_DIR: begin
          repeat ((d.direct_size == DIRECT_SHORT) ? 2 : 4) begin
            write_byte(pos, random_byte());
            pos++;
          end
        end
        KIND_IND: begin
          repeat (2) begin
            write_byte(pos, random_byte());
            pos++;
          end
        end
        default: ;
      endcase
    end
    opcode_sites.push_back(at);
    decode_filled(d);
  endtask

  // arbitrary descriptor, mostly at a known opcode site
  task automatic revisit_decode();
    request_t d;
    d        = '0;
    d.action = ACT_DECODE;
    if (opcode_sites.size() != 0 && $urandom_range(0, 4) != 0)
      d.address = opcode_sites[$urandom_range(0, opcode_sites.size() - 1)];
    else
      d.address = ADDR_W'($urandom_range(0, ARENA_BYTES - 1));
    d.has_type_byte = 1'($urandom_range(0, 1));
    d.arg_count     = CNT_W'($urandom_range(0, 3));
    d.allowed       = (NARGS*ALLOW_W)'($urandom);
    d.direct_size   = DSZ_W'($urandom_range(0, 7));
    decode_filled(d);
  endtask

  // ---- result channel ----

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t: mismatch: %s", $realtime, what);
  endtask

  initial begin
    int unsigned hold;
    rsp_if.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!receiver_calm) hold = pause_len();
      end
    end
  end

  always @(posedge clk_i) begin
    decode_result_t got;
    decode_result_t due;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.kind  = {rsp_if.arg_kind_2, rsp_if.arg_kind_1, rsp_if.arg_kind_0};
      got.value = {rsp_if.arg_value_2, rsp_if.arg_value_1, rsp_if.arg_value_0};
      got.ok    = rsp_if.args_ok;
      got.next  = rsp_if.next_address;
      if (decodes_due.size() == 0) begin
        report_mismatch("result with no decode pending");
      end else begin
        due = decodes_due.pop_front();
        for (int i = 0; i < NARGS; i++) begin
          if (got.kind[i] !== due.kind[i])
            report_mismatch($sformatf("arg_kind_%0d got %0d want %0d",
                                      i, got.kind[i], due.kind[i]));
          if (got.value[i] !== due.value[i])
            report_mismatch($sformatf("arg_value_%0d got %h want %h",
                                      i, got.value[i], due.value[i]));
        end
        if (got.ok !== due.ok)
          report_mismatch($sformatf("args_ok got %b want %b", got.ok, due.ok));
        if (got.next !== due.next)
          report_mismatch($sformatf("next_address got %h want %h", got.next, due.next));
      end
    end
  end

  // ---- watchdog: cycles with no handshake on either side ----

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
      else idle++;
    end
    $display("instruction_operand_decoder test failed");
    $finish;
  end

  // ---- stimulus ----

  initial begin
    int unsigned next_drain;
    int unsigned pick;
    rst_ni                 = 1'b0;
    req_if.valid           = 1'b0;
    req_if.action          = ACT_WRITE;
    req_if.address         = '0;
    req_if.data            = '0;
    req_if.has_type_byte   = 1'b0;
    req_if.arg_count       = '0;
    req_if.allowed_kinds_0 = '0;
    req_if.allowed_kinds_1 = '0;
    req_if.allowed_kinds_2 = '0;
    req_if.direct_size     = '0;
    sender_calm            = 1'b0;
    receiver_calm          = 1'b0;
    mismatches             = 0;
    items_sent             = 0;

    // type byte 0x5C: register, register, indirect, unused pair
    directed_plan = '{
      '{arena_write(12'h000, 8'h01), 1'b0, '0},
      '{arena_write(12'h001, 8'h5C), 1'b0, '0},
      '{arena_write(12'h002, 8'h01), 1'b0, '0},
      '{arena_write(12'h003, 8'h10), 1'b0, '0},
      '{arena_write(12'h004, 8'h80), 1'b0, '0},
      '{arena_write(12'h005, 8'h00), 1'b0, '0},
      '{decode_req(12'h000, 1'b1, 2'd3, 3'd7, 3'd7, 3'd7, 3'd2), 1'b1,
        outcome(KIND_REG, KIND_REG, KIND_IND, 32'd1, 32'd16, 32'hFFFF_8000, 1'b1, 12'h006)},
      '{decode_req(12'h000, 1'b1, 2'd3, 3'd6, 3'd7, 3'd3, 3'd2), 1'b1,
        outcome(KIND_REG, KIND_REG, KIND_IND, 32'd1, 32'd16, 32'hFFFF_8000, 1'b0, 12'h006)},
      '{decode_req(12'h000, 1'b0, 2'd1, 3'd2, 3'd0, 3'd0, 3'd4), 1'b1,
        outcome(KIND_DIR, KIND_NONE, KIND_NONE, 32'h5C01_1080, 32'd0, 32'd0, 1'b1, 12'h005)},
      '{decode_req(12'h000, 1'b0, 2'd3, 3'd0, 3'd7, 3'd7, 3'd2), 1'b1,
        outcome(KIND_DIR, KIND_NONE, KIND_NONE, 32'h0000_5C01, 32'd0, 32'd0, 1'b0, 12'h003)},
      '{decode_req(12'h000, 1'b1, 2'd0, 3'd7, 3'd7, 3'd7, 3'd2), 1'b1,
        outcome(KIND_NONE, KIND_NONE, KIND_NONE, 32'd0, 32'd0, 32'd0, 1'b1, 12'h002)},
      '{decode_req(12'h000, 1'b0, 2'd0, 3'd0, 3'd0, 3'd0, 3'd4), 1'b1,
        outcome(KIND_NONE, KIND_NONE, KIND_NONE, 32'd0, 32'd0, 32'd0, 1'b1, 12'h001)},
      // empty first code, register 128 out of range
      '{decode_req(12'h002, 1'b1, 2'd2, 3'd7, 3'd7, 3'd7, 3'd2), 1'b1,
        outcome(KIND_NONE, KIND_REG, KIND_NONE, 32'd0, 32'd128, 32'd0, 1'b0, 12'h005)},
      '{arena_write(12'hFFE, 8'hAA), 1'b0, '0},
      '{arena_write(12'hFFF, 8'h7F), 1'b0, '0},
      // 4-byte direct wrapping past the arena end
      '{decode_req(12'hFFE, 1'b0, 2'd1, 3'd2, 3'd0, 3'd0, 3'd7), 1'b1,
        outcome(KIND_DIR, KIND_NONE, KIND_NONE, 32'h7F01_5C01, 32'd0, 32'd0, 1'b1, 12'h003)},
      '{decode_req(12'hFFF, 1'b1, 2'd3, 3'd7, 3'd7, 3'd7, 3'd0), 1'b1,
        outcome(KIND_NONE, KIND_NONE, KIND_NONE, 32'd0, 32'd0, 32'd0, 1'b0, 12'h001)},
      '{arena_write(12'h010, 8'hEE), 1'b0, '0},
      '{arena_write(12'h011, 8'h40), 1'b0, '0},
      '{arena_write(12'h012, 8'h00), 1'b0, '0},
      // register zero
      '{decode_req(12'h010, 1'b1, 2'd1, 3'd1, 3'd0, 3'd0, 3'd2), 1'b1,
        outcome(KIND_REG, KIND_NONE, KIND_NONE, 32'd0, 32'd0, 32'd0, 1'b0, 12'h013)},
      '{decode_req(12'h003, 1'b0, 2'd1, 3'd7, 3'd0, 3'd0, 3'd2), 1'b0, '0},
      '{arena_write(12'h013, 8'hFF), 1'b0, '0},
      '{decode_req(12'h011, 1'b0, 2'd1, 3'd5, 3'd0, 3'd0, 3'd2), 1'b0, '0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i])
      send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);
    drain_results();

    next_drain = items_sent + DRAIN_EVERY;
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
      pick = $urandom_range(0, 19);
      if (pick < 11)      fresh_instruction();
      else if (pick < 17) revisit_decode();
      else                write_byte(ADDR_W'($urandom_range(0, ARENA_BYTES - 1)), random_byte());
      if (items_sent >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
    end
    req_if.valid <= 1'b0;

    while (decodes_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) $display("instruction_operand_decoder test passed");
    else $display("instruction_operand_decoder test failed");
    $finish;
  end

endmodule
